/* hw/rtl/dq_pkg.sv */
// dq_pkg: sizes, action codes and transaction types for the double-ended queue.
// No dependencies; imported by dq_cell and double_ended_queue_core.
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ACT_W      = 3;

  // Action codes carried by an input transaction
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_CLEAR      = 3'd4
  } action_t;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    word_t            push_data;
  } in_item_t;

  typedef struct packed {
    word_t            pop_data;
    logic             pop_valid;
    word_t            front_word;
    word_t            back_word;
    logic [CNT_W-1:0] occupancy;
    logic             is_empty;
    logic             push_dropped;
  } out_item_t;

  // Command broadcast to every cell of the chain, already gated by full/empty
  typedef struct packed {
    logic shift_right;  // push front: every word moves one cell toward the back
    logic shift_left;   // pop front: every word moves one cell toward the front
    logic append;       // push back: first free cell takes the word
    logic trunc;        // pop back: last occupied cell lets go
    logic clear;
  } cell_cmd_t;

endpackage

/* hw/rtl/dq_cell.sv */
// dq_cell: one slot of the queue chain, holding a word and an occupied flag.
// Depends on dq_pkg; instantiated DEPTH times by double_ended_queue_core.
module dq_cell import dq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  word_t     push_data,
  input  word_t     left_data,
  input  logic      left_valid,
  input  word_t     right_data,
  input  logic      right_valid,
  output word_t     data,
  output logic      valid,
  output word_t     last_data
);

  word_t data_next;
  logic  valid_next;

  // Next contents from the broadcast command and the neighbors
  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (cmd.clear) begin
      valid_next = 1'b0;
    end else if (cmd.shift_right) begin
      data_next  = left_data;
      valid_next = left_valid;
    end else if (cmd.shift_left) begin
      data_next  = right_data;
      valid_next = right_valid;
    end else if (cmd.append) begin
      if (!valid && left_valid) begin
        data_next  = push_data;
        valid_next = 1'b1;
      end
    end else if (cmd.trunc) begin
      if (valid && !right_valid) begin
        valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Word of the back-most occupied cell, zero elsewhere, for an OR collect
  assign last_data = (valid && !right_valid) ? data : '0;

endmodule

/* hw/rtl/double_ended_queue_core.sv */
// double_ended_queue_core: bounded deque built as a row of shifting cells.
// The result is registered and is valid in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle; every action is an update of all cells
// in parallel, held back only while an unread result stalls.
// Reset (rst, synchronous): queue empty, no result pending; slot words undefined.
// Depends on dq_pkg and dq_cell.
module double_ended_queue_core import dq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  word_t            cell_data      [DEPTH];
  logic             cell_valid     [DEPTH];
  word_t            cell_last_data [DEPTH];
  cell_cmd_t        cmd;
  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] occ_next;
  word_t            pop_data;
  word_t            pop_data_next;
  logic             pop_valid;
  logic             pop_valid_next;
  logic             push_dropped;
  logic             push_dropped_next;
  logic             out_valid_next;
  word_t            back_word;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = cell_valid[DEPTH-1];
  assign empty    = !cell_valid[0];

  // Collect the back word from the one cell that is last
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_last_data[i];
    end
  end

  // Action decode, gated by full and empty
  always_comb begin
    cmd               = '0;
    occ_next          = occ;
    pop_data_next     = pop_data;
    pop_valid_next    = pop_valid;
    push_dropped_next = push_dropped;
    if (accept) begin
      pop_data_next     = '0;
      pop_valid_next    = 1'b0;
      push_dropped_next = 1'b0;
      case (in_data.action)
        ACT_PUSH_BACK: begin
          if (full) begin
            push_dropped_next = 1'b1;
          end else begin
            cmd.append = 1'b1;
            occ_next   = occ + CNT_W'(1);
          end
        end
        ACT_PUSH_FRONT: begin
          if (full) begin
            push_dropped_next = 1'b1;
          end else begin
            cmd.shift_right = 1'b1;
            occ_next        = occ + CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (!empty) begin
            cmd.trunc      = 1'b1;
            pop_data_next  = back_word;
            pop_valid_next = 1'b1;
            occ_next       = occ - CNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (!empty) begin
            cmd.shift_left = 1'b1;
            pop_data_next  = cell_data[0];
            pop_valid_next = 1'b1;
            occ_next       = occ - CNT_W'(1);
          end
        end
        ACT_CLEAR: begin
          cmd.clear = 1'b1;
          occ_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Cell chain: cell 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t l_data;
    logic  l_valid;
    word_t r_data;
    logic  r_valid;

    if (i == 0) begin : g_first
      assign l_data  = in_data.push_data;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .push_data   (in_data.push_data),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .last_data   (cell_last_data[i])
    );
  end

  // Result stage: pending flag and per-transaction flags
  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      occ       <= '0;
    end else begin
      out_valid <= out_valid_next;
      occ       <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    pop_data     <= pop_data_next;
    pop_valid    <= pop_valid_next;
    push_dropped <= push_dropped_next;
  end

  // Cells change only on acceptance, so the state view holds while stalled
  assign out_data.pop_data     = pop_data;
  assign out_data.pop_valid    = pop_valid;
  assign out_data.front_word   = empty ? '0 : cell_data[0];
  assign out_data.back_word    = back_word;
  assign out_data.occupancy    = occ;
  assign out_data.is_empty     = empty;
  assign out_data.push_dropped = push_dropped;

endmodule
